@@ hdl/okle_pkg.sv @@
`default_nettype none

package okle_pkg;

  // list size and derived widths
  localparam int Capacity = 64;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int KeyW     = 32;
  localparam int PosW     = 6;
  localparam int CountW   = 7;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_MODIFY = 2'd2,
    REQ_FIND   = 2'd3
  } req_type_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // per-cell update action
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     valid;
    logic     cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [5:0] position;
    logic [6:0] entry_count;
    status_e    status;
  } rsp_t;

endpackage

`default_nettype wire

@@ hdl/okle_cell.sv @@
`default_nettype none

module okle_cell
  import okle_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic signed [KeyW-1:0] cmp_key_i,
  input  wire logic signed [KeyW-1:0] ld_data_i,
  input  wire logic signed [KeyW-1:0] left_data_i,
  input  wire logic signed [KeyW-1:0] right_data_i,
  output logic signed [KeyW-1:0]      entry_o,
  output logic                        match_o
);

  logic signed [KeyW-1:0] entry_q, entry_d;
  logic                   match_q, match_d;

  // entry update from neighbours or load data
  always_comb begin
    case (ctrl_i.op)
      CELL_HOLD:       entry_d = entry_q;
      CELL_FROM_LEFT:  entry_d = left_data_i;
      CELL_FROM_RIGHT: entry_d = right_data_i;
      CELL_LOAD:       entry_d = ld_data_i;
      default:         entry_d = entry_q;
    endcase
  end

  // compare against the searched key, only live entries count
  assign match_d = ctrl_i.cmp_en ? (ctrl_i.valid && (entry_q == cmp_key_i)) : match_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ hdl/okle_first_hit.sv @@
`default_nettype none

module okle_first_hit
  import okle_pkg::*;
(
  input  wire logic [Capacity-1:0] match_i,
  output logic                     any_o,
  output logic [Capacity-1:0]      onehot_o,
  output logic [Capacity-1:0]      from_hit_o,
  output logic [IdxW-1:0]          pos_o
);

  logic [Capacity-1:0] upto_hit;

  // bits up to and including the lowest match
  assign upto_hit   = match_i ^ (match_i - Capacity'(1));
  assign any_o      = |match_i;
  assign onehot_o   = upto_hit & match_i;
  assign from_hit_o = ~upto_hit | onehot_o;

  // encode the one-hot position
  always_comb begin
    pos_o = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (onehot_o[i]) begin
        pos_o = pos_o | IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/ordered_key_list_engine.sv @@
// channel | signals                          | beat
// --------+----------------------------------+-----------------------------------
// request | in_valid_i, in_ready_o, in_req_i | req_type, key, new_value
// result  | out_valid_o, out_ready_i,        | found, position, entry_count,
//         | out_rsp_o                        | status
//
// each request runs as a compare in every cell, then first-match
// select and a one-step shift or write along the cell row
// reset clears the entry count and the control state; entries are not cleared
// a stalled result holds in the output register; the next request is taken
// once that register is empty or being drained in the same cycle
`default_nettype none

module ordered_key_list_engine
  import okle_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                   state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   rsp_q, rsp_d;
  req_type_e              type_q;
  logic signed [KeyW-1:0] key_q, nv_q;

  logic                   accept;
  logic                   is_full, is_empty;
  logic                   ins_ok, del_hit, mod_hit;
  logic [Capacity-1:0]    match, onehot, from_hit;
  logic                   any_hit;
  logic [IdxW-1:0]        hit_pos;
  logic signed [KeyW-1:0] entry [Capacity];
  cell_ctrl_t             ctrl [Capacity];

  logic [IdxW+PosW-1:0]   pos_ext;
  logic [CntW+CountW-1:0] cnt_ext;

  // handshake
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);

  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);
  assign ins_ok   = (state_q == S_EXEC) && (type_q == REQ_INSERT) && !is_full;
  assign del_hit  = (state_q == S_EXEC) && (type_q == REQ_DELETE) && !is_empty && any_hit;
  assign mod_hit  = (state_q == S_EXEC) && (type_q == REQ_MODIFY) && !is_empty && any_hit;

  // row of cells
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic signed [KeyW-1:0] left_data, right_data;

    if (g == 0) begin : g_head
      assign left_data = key_q;
    end else begin : g_body
      assign left_data = entry[g-1];
    end
    if (g == Capacity - 1) begin : g_tail
      assign right_data = entry[g];
    end else begin : g_inner
      assign right_data = entry[g+1];
    end

    // per-cell control
    always_comb begin
      ctrl[g].valid  = (count_q > CntW'(g));
      ctrl[g].cmp_en = accept;
      if (ins_ok) begin
        ctrl[g].op = CELL_FROM_LEFT;
      end else if (del_hit && from_hit[g]) begin
        ctrl[g].op = CELL_FROM_RIGHT;
      end else if (mod_hit && onehot[g]) begin
        ctrl[g].op = CELL_LOAD;
      end else begin
        ctrl[g].op = CELL_HOLD;
      end
    end

    okle_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .cmp_key_i    (in_req_i.key),
      .ld_data_i    (nv_q),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .entry_o      (entry[g]),
      .match_o      (match[g])
    );
  end

  // first match select
  okle_first_hit u_first_hit (
    .match_i    (match),
    .any_o      (any_hit),
    .onehot_o   (onehot),
    .from_hit_o (from_hit),
    .pos_o      (hit_pos)
  );

  // next count, state and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    pos_ext     = '0;
    cnt_ext     = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (ins_ok) begin
          count_d = count_q + CntW'(1);
        end else if (del_hit) begin
          count_d = count_q - CntW'(1);
        end
        pos_ext = {{PosW{1'b0}}, hit_pos};
        cnt_ext = {{CountW{1'b0}}, count_d};
        rsp_d.found       = 1'b0;
        rsp_d.position    = '0;
        rsp_d.entry_count = cnt_ext[CountW-1:0];
        if (type_q == REQ_INSERT) begin
          rsp_d.status = is_full ? ST_FULL : ST_OK;
        end else if (is_empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (!any_hit) begin
          rsp_d.status = ST_NOTFOUND;
        end else begin
          rsp_d.status   = ST_OK;
          rsp_d.found    = 1'b1;
          rsp_d.position = pos_ext[PosW-1:0];
        end
        out_valid_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      type_q <= in_req_i.req_type;
      key_q  <= in_req_i.key;
      nv_q   <= in_req_i.new_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count beyond capacity");

  a_out_free_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !out_valid_q)
    else $error("result register busy while executing");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> out_valid_q)
    else $error("execute cycle produced no result");

  a_count_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("entry count changed outside execute");

endmodule

`default_nettype wire

@@ tb/ordered_key_list_engine_tb.sv @@
`default_nettype none

module ordered_key_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import okle_pkg::*;

  localparam int RandomItems = 750;

  typedef struct {
    req_t req;
    bit   hold_for_drain;
  } pending_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_TOGGLE} rx_mode_e;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_req    = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;

  // request beats waiting to go out, and results owed by the block
  pending_t pending_reqs[$];
  rsp_t     expected_rsps[$];

  // shadow copy of the list
  logic [KeyW-1:0] shadow_list [Capacity];
  int              list_held = 0;

  // run statistics
  int op_cnt[4]   = '{0, 0, 0, 0};
  int match_cnt   = 0;
  int miss_cnt    = 0;
  int full_cnt    = 0;
  int empty_cnt   = 0;
  int peak_fill   = 0;
  int err_cnt     = 0;
  int results_seen = 0;

  // sender and receiver pacing
  int       gap_left   = 0;
  int       burst_left = 0;
  int       rx_left    = 0;
  int       hold_left  = 0;
  int       hold_idx   = 0;
  rx_mode_e rx_mode    = RX_ALWAYS;

  logic [31:0] key_pool[8];

  ordered_key_list_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #6 clk_i = ~clk_i;

  // apply one request to the shadow list and return the result it owes
  function automatic rsp_t list_apply(req_t r);
    rsp_t res;
    int   hit;
    res        = '0;
    res.status = ST_OK;
    hit        = -1;
    op_cnt[int'(r.req_type)]++;
    if (r.req_type == REQ_INSERT) begin
      if (list_held >= Capacity) begin
        res.status = ST_FULL;
        full_cnt++;
      end else begin
        for (int i = list_held; i > 0; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[0] = r.key;
        list_held++;
        if (list_held > peak_fill) peak_fill = list_held;
      end
    end else if (list_held == 0) begin
      res.status = ST_EMPTY;
      empty_cnt++;
    end else begin
      // first match counted from the head, full 32-bit compare
      for (int i = 0; i < list_held; i++)
        if (hit < 0 && shadow_list[i] == r.key) hit = i;
      if (hit < 0) begin
        res.status = ST_NOTFOUND;
        miss_cnt++;
      end else begin
        res.found    = 1'b1;
        res.position = hit[PosW-1:0];
        match_cnt++;
        if (r.req_type == REQ_DELETE) begin
          for (int i = hit; i < list_held - 1; i++) shadow_list[i] = shadow_list[i+1];
          list_held--;
        end else if (r.req_type == REQ_MODIFY) begin
          shadow_list[hit] = r.new_value;
        end
      end
    end
    res.entry_count = list_held[CountW-1:0];
    return res;
  endfunction

  task automatic queue_req(req_type_e t, logic [31:0] k, logic [31:0] nv, bit hold);
    pending_t p;
    p.req.req_type  = t;
    p.req.key       = k;
    p.req.new_value = nv;
    p.hold_for_drain = hold;
    pending_reqs.push_back(p);
  endtask

  // new pool key, now and then one of the extremes
  function automatic logic [31:0] fresh_key();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_key(int pool_pct);
    if ($urandom_range(99) < pool_pct) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // request driver: bursts of beats with random gaps
  always @(posedge clk_i) begin
    logic     offer;
    req_t     nxt;
    pending_t head;
    offer = in_valid;
    nxt   = in_req;
    if (!rst_ni) begin
      offer = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(list_apply(in_req));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold_for_drain && expected_rsps.size() != 0)) begin
          head  = pending_reqs.pop_front();
          nxt   = head.req;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    in_valid <= offer;
    in_req   <= nxt;
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    logic rdy;
    rsp_t want;
    rdy = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0h",
                   $time, out_rsp);
          err_cnt++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("found", want.found, out_rsp.found);
          check_field("position", want.position, out_rsp.position);
          check_field("entry_count", want.entry_count, out_rsp.entry_count);
          check_field("status", want.status, out_rsp.status);
        end
      end
      // long hold-offs so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
      end else if ((hold_idx == 0 && results_seen >= 200) ||
                   (hold_idx == 1 && results_seen >= 520)) begin
        hold_idx++;
        hold_left = 90;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(3));
          rx_left = $urandom_range(10, 60);
        end else begin
          rx_left--;
        end
        case (rx_mode)
          RX_ALWAYS: rdy = 1'b1;
          RX_MOSTLY: rdy = ($urandom_range(3) != 0);
          RX_SELDOM: rdy = ($urandom_range(3) == 0);
          default:   rdy = !out_ready;
        endcase
      end
    end
    out_ready <= rdy;
  end

  // stimulus and end of run
  initial begin
    phase_e    kind;
    req_type_e t;
    int        phase_len;
    int        roll;
    int        made;
    logic [31:0] nv;
    made = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = fresh_key();

    // directed: empty list, extremes, first match, head and tail removal
    queue_req(REQ_FIND,   32'h0000_0000, $urandom, 0);
    queue_req(REQ_DELETE, 32'h8000_0000, $urandom, 0);
    queue_req(REQ_MODIFY, 32'hFFFF_FFFF, $urandom, 0);
    queue_req(REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    queue_req(REQ_INSERT, 32'h7FFF_FFFF, $urandom, 0);
    queue_req(REQ_INSERT, 32'h0000_0000, 32'h8000_0000, 0);
    queue_req(REQ_INSERT, 32'hFFFF_FFFF, $urandom, 0);
    queue_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    queue_req(REQ_FIND,   32'h7FFF_FFFF, $urandom, 0);
    queue_req(REQ_FIND,   32'h8000_0000, $urandom, 0);
    queue_req(REQ_FIND,   32'h0000_0001, $urandom, 0);
    queue_req(REQ_DELETE, 32'h0000_0005, $urandom, 0);
    queue_req(REQ_MODIFY, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 0);
    queue_req(REQ_FIND,   32'h5A5A_A5A5, $urandom, 0);
    queue_req(REQ_MODIFY, 32'h1234_5678, $urandom, 0);
    queue_req(REQ_DELETE, 32'h7FFF_FFFF, $urandom, 0);
    queue_req(REQ_FIND,   32'h7FFF_FFFF, $urandom, 0);
    queue_req(REQ_DELETE, 32'h8000_0000, $urandom, 0);
    queue_req(REQ_DELETE, 32'h0000_0000, $urandom, 0);
    queue_req(REQ_DELETE, 32'h5A5A_A5A5, $urandom, 0);
    queue_req(REQ_DELETE, 32'h7FFF_FFFF, $urandom, 0);
    queue_req(REQ_FIND,   32'h7FFF_FFFF, $urandom, 0);

    // random phases over a small key pool so matches are common;
    // the first phase fills the list past capacity, the next one drains it
    while (made < RandomItems) begin
      if (made == 0) begin
        kind      = PH_FILL;
        phase_len = 100;
      end else if (made == 100) begin
        kind      = PH_DRAIN;
        phase_len = 90;
      end else begin
        kind      = phase_e'($urandom_range(2));
        phase_len = $urandom_range(40, 100);
      end
      for (int j = 0; j < 4; j++) key_pool[$urandom_range(7)] = fresh_key();
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(99);
        case (kind)
          PH_FILL:  t = (roll < 85) ? REQ_INSERT : (roll < 90) ? REQ_DELETE :
                        (roll < 95) ? REQ_MODIFY : REQ_FIND;
          PH_DRAIN: t = (roll < 10) ? REQ_INSERT : (roll < 75) ? REQ_DELETE :
                        (roll < 87) ? REQ_MODIFY : REQ_FIND;
          default:  t = (roll < 25) ? REQ_INSERT : (roll < 50) ? REQ_DELETE :
                        (roll < 75) ? REQ_MODIFY : REQ_FIND;
        endcase
        nv = ($urandom_range(1) == 0) ? key_pool[$urandom_range(7)] : $urandom;
        // each phase after the first opens once the block has gone quiet
        queue_req(t, pick_key((t == REQ_INSERT) ? 95 : 85), nv, (i == 0) && (made != 0));
        made++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("ordered_key_list_engine_tb: %0d ins, %0d del, %0d mod, %0d find, %0d checked",
             op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], results_seen);
    $display("  %0d hits, %0d misses, %0d full refusals, %0d on empty, peak fill %0d/%0d",
             match_cnt, miss_cnt, full_cnt, empty_cnt, peak_fill, Capacity);
    if (err_cnt == 0) begin
      $display("ordered_key_list_engine_tb: done, clean");
    end else begin
      $display("ordered_key_list_engine_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("ordered_key_list_engine_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
